// ===== rtl/core/vdm_pkg.sv =====
// ----------------------------------------------------------------------------
// Vector distance metric package
// Shared types and constants for the metric modes, status codes and back end.
// ----------------------------------------------------------------------------
package vdm_pkg;

    localparam int VALUE_W   = 48;
    localparam int STATUS_W  = 2;
    localparam int MODE_W    = 2;
    localparam int COS_SHIFT = 60;
    localparam int Q_W       = 31;

    localparam logic [MODE_W-1:0] MODE_COSINE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INNER  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_L2     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET  = MODE_L2;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LONG = 2'd2;

    localparam logic [31:0] ONE_Q16 = 32'd65536;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_ROOT,
        BK_OUT
    } bk_state_t;

endpackage

// ===== rtl/core/vdm_front.sv =====
// ----------------------------------------------------------------------------
// Vector distance metric front end
// Accepts element pairs, forms the four products and keeps the running sums.
// ----------------------------------------------------------------------------
module vdm_front #(
    parameter int ELEM_WIDTH = 16,
    parameter int MAX_DIM    = 1024,
    parameter int ACC_W      = 44
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [ELEM_WIDTH-1:0] elem_a,
    input  logic signed [ELEM_WIDTH-1:0] elem_b,
    input  logic                         last_elem,
    output logic                         push_valid,
    input  logic                         push_ready,
    output logic        [ACC_W-1:0]      push_dot,
    output logic        [ACC_W-1:0]      push_mag_a,
    output logic        [ACC_W-1:0]      push_mag_b,
    output logic        [ACC_W-1:0]      push_dsq,
    output logic                         push_long
);

    localparam int EW    = ELEM_WIDTH;
    localparam int CNT_W = $clog2(MAX_DIM + 1);
    localparam int XW    = (ACC_W > 2 * EW + 2) ? ACC_W : 2 * EW + 2;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             long_reg, long_next;
    logic             s1_valid_reg, s1_last_reg, s1_long_reg;
    logic signed [2*EW-1:0] p_dot_reg;
    logic [2*EW-1:0]  p_ma_reg, p_mb_reg;
    logic [2*EW:0]    p_dsq_reg;
    logic [ACC_W-1:0] dot_reg, ma_reg, mb_reg, dsq_reg;
    logic [ACC_W-1:0] dot_sum, ma_sum, mb_sum, dsq_sum;
    logic             accept, skip, s1_go;
    logic signed [EW:0]     diff;
    logic signed [2*EW-1:0] prod_ab, prod_aa, prod_bb;
    logic signed [2*EW+1:0] prod_dd;
    logic [XW-1:0]    x_dot, x_ma, x_mb, x_dsq;

    assign skip    = (count_reg == CNT_W'(MAX_DIM));
    assign s1_go   = s1_valid_reg && !(s1_last_reg && !push_ready);
    assign in_ready = !s1_valid_reg || s1_go;
    assign accept  = in_valid && in_ready;

    assign diff    = {elem_a[EW-1], elem_a} - {elem_b[EW-1], elem_b};
    assign prod_ab = elem_a * elem_b;
    assign prod_aa = elem_a * elem_a;
    assign prod_bb = elem_b * elem_b;
    assign prod_dd = diff * diff;

    always_comb
    begin
        count_next = count_reg;
        long_next  = long_reg;
        if (accept)
        begin
            if (last_elem)
            begin
                count_next = '0;
                long_next  = 1'b0;
            end
            else
            begin
                if (!skip)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                long_next = long_reg | skip;
            end
        end
    end

    assign x_dot = {{(XW - 2 * EW){p_dot_reg[2*EW-1]}}, p_dot_reg};
    assign x_ma  = {{(XW - 2 * EW){1'b0}}, p_ma_reg};
    assign x_mb  = {{(XW - 2 * EW){1'b0}}, p_mb_reg};
    assign x_dsq = {{(XW - 2 * EW - 1){1'b0}}, p_dsq_reg};

    assign dot_sum = dot_reg + x_dot[ACC_W-1:0];
    assign ma_sum  = ma_reg + x_ma[ACC_W-1:0];
    assign mb_sum  = mb_reg + x_mb[ACC_W-1:0];
    assign dsq_sum = dsq_reg + x_dsq[ACC_W-1:0];

    assign push_valid = s1_valid_reg && s1_last_reg;
    assign push_dot   = dot_sum;
    assign push_mag_a = ma_sum;
    assign push_mag_b = mb_sum;
    assign push_dsq   = dsq_sum;
    assign push_long  = s1_long_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            long_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s1_long_reg  <= 1'b0;
            dot_reg      <= '0;
            ma_reg       <= '0;
            mb_reg       <= '0;
            dsq_reg      <= '0;
        end
        else
        begin
            count_reg <= count_next;
            long_reg  <= long_next;
            if (in_ready)
            begin
                s1_valid_reg <= accept;
                s1_last_reg  <= last_elem;
                s1_long_reg  <= long_reg | skip;
            end
            if (s1_go)
            begin
                if (s1_last_reg)
                begin
                    dot_reg <= '0;
                    ma_reg  <= '0;
                    mb_reg  <= '0;
                    dsq_reg <= '0;
                end
                else
                begin
                    dot_reg <= dot_sum;
                    ma_reg  <= ma_sum;
                    mb_reg  <= mb_sum;
                    dsq_reg <= dsq_sum;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_dot_reg <= skip ? '0 : prod_ab;
            p_ma_reg  <= skip ? '0 : prod_aa;
            p_mb_reg  <= skip ? '0 : prod_bb;
            p_dsq_reg <= skip ? '0 : prod_dd[2*EW:0];
        end
    end

endmodule

// ===== rtl/core/vdm_queue.sv =====
// ----------------------------------------------------------------------------
// Vector distance metric queue
// Small register queue holding finished sums between front and back end.
// ----------------------------------------------------------------------------
module vdm_queue #(
    parameter int WIDTH = 177,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_wr, do_rd;

    assign wr_ready = (cnt_reg != CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/vdm_back.sv =====
// ----------------------------------------------------------------------------
// Vector distance metric back end
// Turns one set of sums into a result; cosine uses a shift-add multiplier
// followed by a bit-serial square-root-and-divide search.
// ----------------------------------------------------------------------------
module vdm_back #(
    parameter int ACC_W = 44
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rec_valid,
    output logic                              rec_ready,
    input  logic [ACC_W-1:0]                  rec_dot,
    input  logic [ACC_W-1:0]                  rec_mag_a,
    input  logic [ACC_W-1:0]                  rec_mag_b,
    input  logic [ACC_W-1:0]                  rec_dsq,
    input  logic                              rec_long,
    input  logic [vdm_pkg::MODE_W-1:0]        mode,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [vdm_pkg::VALUE_W-1:0]       metric_value,
    output logic [vdm_pkg::STATUS_W-1:0]      status
);

    localparam int VW   = vdm_pkg::VALUE_W;
    localparam int QW   = vdm_pkg::Q_W;
    localparam int PW   = 2 * ACC_W;
    localparam int WIDE = PW + vdm_pkg::COS_SHIFT + 2;
    localparam int MC_W = $clog2(ACC_W);
    localparam int IW   = (ACC_W + 2 > VW + 2) ? ACC_W + 2 : VW + 2;
    localparam int UW   = (ACC_W > VW) ? ACC_W : VW;

    localparam logic signed [IW-1:0] SAT_HI_I = (IW'(1) <<< (VW - 1)) - IW'(1);
    localparam logic signed [IW-1:0] SAT_LO_I = -SAT_HI_I - IW'(1);
    localparam logic [UW-1:0]        SAT_HI_U = (UW'(1) << (VW - 1)) - UW'(1);

    vdm_pkg::bk_state_t state_reg, state_next;

    logic [MC_W-1:0] mul_cnt_reg;
    logic [PW-1:0]   mcd_reg, pd_reg, mcm_reg, pm_reg;
    logic [ACC_W-1:0] mpd_reg, mpm_reg;
    logic            neg_reg;
    logic [WIDE-1:0] r_reg, a_reg, b_reg;
    logic [QW-1:0]   q_reg, kbit_reg;
    logic [VW-1:0]   res_value_reg;
    logic [vdm_pkg::STATUS_W-1:0] res_status_reg;
    logic            out_valid_reg;
    logic [VW-1:0]   out_value_reg;
    logic [vdm_pkg::STATUS_W-1:0] out_status_reg;

    logic            pop, load_out, mul_last, root_last, take;
    logic            go_cos;
    logic [ACC_W-1:0] dot_abs;
    logic [WIDE:0]   sum_ab, a_step;
    logic [QW-1:0]   q_new;
    logic signed [IW-1:0] inner_x;
    logic [UW-1:0]   dsq_x;
    logic [VW-1:0]   fast_value;
    logic [vdm_pkg::STATUS_W-1:0] fast_status;

    assign dot_abs = rec_dot[ACC_W-1] ? (ACC_W'(0) - rec_dot) : rec_dot;
    assign inner_x = IW'(signed'({1'b0, vdm_pkg::ONE_Q16}))
                     - {{(IW - ACC_W){rec_dot[ACC_W-1]}}, rec_dot};
    assign dsq_x   = UW'(rec_dsq);
    assign go_cos  = !rec_long && (mode == vdm_pkg::MODE_COSINE)
                     && (rec_mag_a != '0) && (rec_mag_b != '0);

    always_comb
    begin
        fast_value  = '0;
        fast_status = vdm_pkg::STATUS_OK;
        if (rec_long)
        begin
            fast_status = vdm_pkg::STATUS_LONG;
        end
        else if (mode == vdm_pkg::MODE_COSINE)
        begin
            fast_status = vdm_pkg::STATUS_ZERO;
        end
        else if (mode == vdm_pkg::MODE_INNER)
        begin
            if (inner_x > SAT_HI_I)
            begin
                fast_value = SAT_HI_I[VW-1:0];
            end
            else if (inner_x < SAT_LO_I)
            begin
                fast_value = SAT_LO_I[VW-1:0];
            end
            else
            begin
                fast_value = inner_x[VW-1:0];
            end
        end
        else
        begin
            fast_value = (dsq_x > SAT_HI_U) ? SAT_HI_U[VW-1:0] : dsq_x[VW-1:0];
        end
    end

    assign mul_last  = (mul_cnt_reg == '0);
    assign root_last = kbit_reg[0];
    assign sum_ab    = {1'b0, a_reg} + {1'b0, b_reg};
    assign take      = !q_reg[QW-1] && (sum_ab <= {1'b0, r_reg});
    assign a_step    = take ? ({1'b0, a_reg} + {b_reg, 1'b0}) : {1'b0, a_reg};
    assign q_new     = take ? (q_reg | kbit_reg) : q_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vdm_pkg::BK_IDLE:
            begin
                if (rec_valid)
                begin
                    state_next = go_cos ? vdm_pkg::BK_MUL : vdm_pkg::BK_OUT;
                end
            end
            vdm_pkg::BK_MUL:
            begin
                if (mul_last)
                begin
                    state_next = vdm_pkg::BK_ROOT;
                end
            end
            vdm_pkg::BK_ROOT:
            begin
                if (root_last)
                begin
                    state_next = vdm_pkg::BK_OUT;
                end
            end
            vdm_pkg::BK_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = vdm_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = vdm_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            vdm_pkg::BK_IDLE: pop      = rec_valid;
            vdm_pkg::BK_OUT:  load_out = !out_valid_reg || out_ready;
            default:
            begin
                pop      = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    assign rec_ready    = pop;
    assign out_valid    = out_valid_reg;
    assign metric_value = out_value_reg;
    assign status       = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vdm_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
        end
        if (pop)
        begin
            res_value_reg  <= fast_value;
            res_status_reg <= fast_status;
            neg_reg        <= rec_dot[ACC_W-1];
            mcd_reg        <= PW'(dot_abs);
            mpd_reg        <= dot_abs;
            pd_reg         <= '0;
            mcm_reg        <= PW'(rec_mag_a);
            mpm_reg        <= rec_mag_b;
            pm_reg         <= '0;
            mul_cnt_reg    <= MC_W'(ACC_W - 1);
        end
        if (state_reg == vdm_pkg::BK_MUL)
        begin
            if (mul_last)
            begin
                r_reg    <= {2'b00, (mpd_reg[0] ? pd_reg + mcd_reg : pd_reg),
                             {vdm_pkg::COS_SHIFT{1'b0}}};
                b_reg    <= {2'b00, (mpm_reg[0] ? pm_reg + mcm_reg : pm_reg),
                             {vdm_pkg::COS_SHIFT{1'b0}}};
                a_reg    <= '0;
                q_reg    <= '0;
                kbit_reg <= {1'b1, {(QW - 1){1'b0}}};
            end
            else
            begin
                if (mpd_reg[0])
                begin
                    pd_reg <= pd_reg + mcd_reg;
                end
                if (mpm_reg[0])
                begin
                    pm_reg <= pm_reg + mcm_reg;
                end
                mcd_reg     <= {mcd_reg[PW-2:0], 1'b0};
                mcm_reg     <= {mcm_reg[PW-2:0], 1'b0};
                mpd_reg     <= {1'b0, mpd_reg[ACC_W-1:1]};
                mpm_reg     <= {1'b0, mpm_reg[ACC_W-1:1]};
                mul_cnt_reg <= mul_cnt_reg - MC_W'(1);
            end
        end
        if (state_reg == vdm_pkg::BK_ROOT)
        begin
            if (take)
            begin
                r_reg <= r_reg - sum_ab[WIDE-1:0];
            end
            a_reg    <= a_step[WIDE:1];
            b_reg    <= {2'b00, b_reg[WIDE-1:2]};
            q_reg    <= q_new;
            kbit_reg <= {1'b0, kbit_reg[QW-1:1]};
            if (root_last)
            begin
                res_value_reg  <= neg_reg ? (VW'(0) - VW'(q_new)) : VW'(q_new);
                res_status_reg <= vdm_pkg::STATUS_OK;
            end
        end
    end

endmodule

// ===== rtl/core/vector_distance_metric_top.sv =====
// ----------------------------------------------------------------------------
// Vector distance metric top level
// Streams two vectors as element pairs and gives one distance per vector.
// ----------------------------------------------------------------------------
// Element pairs enter on the in_valid/in_ready channel, one pair per
// transaction, and the pair with last_elem set closes the vector. The front
// end takes one pair per cycle while no closing pair waits for queue room and
// keeps the sums; each closed vector moves through a two-entry queue to the
// back end, which gives one result transaction on out_valid/out_ready. The
// metric is picked by a write on the cfg channel; the user must write it only
// while the block is idle, as the block itself does not enforce this.
// cfg_ready is always high. Inner-product and squared Euclidean results pass
// through the product, queue, back end result and output registers. A cosine
// result also passes the serial multiplier and the 31-step root search in the
// back end; meanwhile pairs stream on until a closing pair finds the queue full.
// Reset clears all sums, the queue and the output, and sets squared
// Euclidean mode. When the receiver stalls, the output register holds its
// result, the back end and queue fill, and then in_ready drops.
// ----------------------------------------------------------------------------
module vector_distance_metric_top #(
    parameter int MAX_DIM    = 1024,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [ELEM_WIDTH-1:0]        elem_a,
    input  logic signed [ELEM_WIDTH-1:0]        elem_b,
    input  logic                                last_elem,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [vdm_pkg::VALUE_W-1:0]  metric_value,
    output logic        [vdm_pkg::STATUS_W-1:0] status,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic        [vdm_pkg::MODE_W-1:0]   cfg_data
);

    localparam int ACC_RAW = 2 * ELEM_WIDTH + $clog2(MAX_DIM + 1) + 1;
    localparam int ACC_W   = (ACC_RAW > 64) ? 64 : ACC_RAW;
    localparam int REC_W   = 4 * ACC_W + 1;

    logic [vdm_pkg::MODE_W-1:0] mode_reg;
    logic             push_valid, push_ready, push_long;
    logic [ACC_W-1:0] push_dot, push_mag_a, push_mag_b, push_dsq;
    logic             rec_valid, rec_ready;
    logic [REC_W-1:0] rec_data;
    logic [vdm_pkg::VALUE_W-1:0] value_raw;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= vdm_pkg::MODE_RESET;
        end
        else if (cfg_valid)
        begin
            mode_reg <= cfg_data;
        end
    end

    vdm_front #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .MAX_DIM    (MAX_DIM),
        .ACC_W      (ACC_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .elem_a     (elem_a),
        .elem_b     (elem_b),
        .last_elem  (last_elem),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_dot   (push_dot),
        .push_mag_a (push_mag_a),
        .push_mag_b (push_mag_b),
        .push_dsq   (push_dsq),
        .push_long  (push_long)
    );

    vdm_queue #(
        .WIDTH (REC_W),
        .DEPTH (2)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  ({push_long, push_dsq, push_mag_b, push_mag_a, push_dot}),
        .rd_valid (rec_valid),
        .rd_ready (rec_ready),
        .rd_data  (rec_data)
    );

    vdm_back #(
        .ACC_W (ACC_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rec_valid    (rec_valid),
        .rec_ready    (rec_ready),
        .rec_dot      (rec_data[ACC_W-1:0]),
        .rec_mag_a    (rec_data[2*ACC_W-1:ACC_W]),
        .rec_mag_b    (rec_data[3*ACC_W-1:2*ACC_W]),
        .rec_dsq      (rec_data[4*ACC_W-1:3*ACC_W]),
        .rec_long     (rec_data[REC_W-1]),
        .mode         (mode_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .metric_value (value_raw),
        .status       (status)
    );

    assign metric_value = signed'(value_raw);

endmodule

// ===== tb/vdm_checker.sv =====
// ----------------------------------------------------------------------------
// Vector distance metric checker
// Watches the pair, result and configuration channels and keeps its own copy
// of the running sums and the metric mode. On each closing pair it predicts
// one result, which is compared field by field with the next result
// transaction. It hands the mismatch count and the number of outstanding
// results to the testbench top.
// ----------------------------------------------------------------------------
module vdm_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic signed [15:0]                  elem_a,
    input  logic signed [15:0]                  elem_b,
    input  logic                                last_elem,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [vdm_pkg::VALUE_W-1:0]  metric_value,
    input  logic        [vdm_pkg::STATUS_W-1:0] status,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic        [vdm_pkg::MODE_W-1:0]   cfg_data,
    output int                                  fail_count,
    output int                                  pending
);

    localparam int VW = vdm_pkg::VALUE_W;
    localparam int DIM_LIMIT = 1024;
    localparam logic signed [63:0] SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    typedef struct {
        logic signed [VW-1:0]                value;
        logic        [vdm_pkg::STATUS_W-1:0] code;
    } metric_result_t;

    metric_result_t     expected_results[$];
    logic [vdm_pkg::MODE_W-1:0] mode;
    logic signed [63:0] dot_acc;
    logic [63:0]        mag_a_acc;
    logic [63:0]        mag_b_acc;
    logic [63:0]        diff_acc;
    int                 count;
    logic               overlong;

    function automatic logic signed [VW-1:0] cosine_q30(
        input logic signed [63:0] dot, input logic [63:0] ma, input logic [63:0] mb);
        logic [255:0] bound;
        logic [255:0] norm;
        logic [63:0]  mag;
        logic [63:0]  q;
        logic [63:0]  c;
        mag = (dot < 0) ? 64'(-dot) : 64'(dot);
        bound = (256'(mag) * 256'(mag)) << 60;
        norm = 256'(ma) * 256'(mb);
        q = 0;
        for (int bit_i = 30; bit_i >= 0; bit_i--) begin
            c = q | (64'd1 << bit_i);
            if (c <= (64'd1 << 30) && 256'(c * c) * norm <= bound)
                q = c;
        end
        return (dot < 0) ? -VW'(q) : VW'(q);
    endfunction

    function automatic metric_result_t close_vector();
        metric_result_t r;
        logic signed [63:0] t;
        r.value = '0;
        r.code = vdm_pkg::STATUS_OK;
        if (overlong) begin
            r.code = vdm_pkg::STATUS_LONG;
        end else if (mode == vdm_pkg::MODE_COSINE) begin
            if (mag_a_acc == 0 || mag_b_acc == 0)
                r.code = vdm_pkg::STATUS_ZERO;
            else
                r.value = cosine_q30(dot_acc, mag_a_acc, mag_b_acc);
        end else if (mode == vdm_pkg::MODE_INNER) begin
            t = 64'sd65536 - dot_acc;
            if (t > SAT_HI)
                t = SAT_HI;
            else if (t < SAT_LO)
                t = SAT_LO;
            r.value = t[VW-1:0];
        end else begin
            r.value = (diff_acc > 64'(SAT_HI)) ? SAT_HI[VW-1:0] : diff_acc[VW-1:0];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] d;
        metric_result_t     got;
        if (!rst_n)
        begin
            mode = vdm_pkg::MODE_RESET;
            dot_acc = 0;
            mag_a_acc = 0;
            mag_b_acc = 0;
            diff_acc = 0;
            count = 0;
            overlong = 1'b0;
            fail_count = 0;
            pending = 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mode = cfg_data;
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with none expected: metric_value %0d status %0d",
                           metric_value, status);
                    fail_count++;
                end
                else
                begin
                    got = expected_results.pop_front();
                    if (metric_value !== got.value)
                    begin
                        $error("metric_value: expected %0d, actual %0d", got.value, metric_value);
                        fail_count++;
                    end
                    if (status !== got.code)
                    begin
                        $error("status: expected %0d, actual %0d", got.code, status);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (count >= DIM_LIMIT)
                begin
                    overlong = 1'b1;
                end
                else
                begin
                    a = elem_a;
                    b = elem_b;
                    d = a - b;
                    dot_acc += a * b;
                    mag_a_acc += 64'(a * a);
                    mag_b_acc += 64'(b * b);
                    diff_acc += 64'(d * d);
                    count++;
                end
                if (last_elem)
                begin
                    expected_results = {expected_results, close_vector()};
                    dot_acc = 0;
                    mag_a_acc = 0;
                    mag_b_acc = 0;
                    diff_acc = 0;
                    count = 0;
                    overlong = 1'b0;
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Vector distance metric testbench
// Streams directed and random vectors through the block in every metric mode,
// with random gaps on both channels, a long receiver stall and one overlong
// vector. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 120;
    localparam int MW = vdm_pkg::MODE_W;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_ready;
    logic signed [15:0]                  elem_a;
    logic signed [15:0]                  elem_b;
    logic                                last_elem;
    logic                                out_valid;
    logic                                out_ready;
    logic signed [vdm_pkg::VALUE_W-1:0]  metric_value;
    logic        [vdm_pkg::STATUS_W-1:0] status;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic        [MW-1:0]                cfg_data;
    int                                  fail_count;
    int                                  pending;
    int                                  tx_idle_pct;
    int                                  rx_idle_pct;
    int                                  rx_hold;
    int                                  cycles;
    int                                  pairs_sent;

    vector_distance_metric_top #(.MAX_DIM(1024), .ELEM_WIDTH(16)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .elem_a(elem_a), .elem_b(elem_b), .last_elem(last_elem),
        .out_valid(out_valid), .out_ready(out_ready),
        .metric_value(metric_value), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    vdm_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .elem_a(elem_a), .elem_b(elem_b), .last_elem(last_elem),
        .out_valid(out_valid), .out_ready(out_ready),
        .metric_value(metric_value), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            out_ready <= 1'b0;
            rx_hold--;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic signed [15:0] pick_elem();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sd0;
            3: return 16'(int'($urandom_range(512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                             input logic closing);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        elem_a <= a;
        elem_b <= b;
        last_elem <= closing;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pairs_sent++;
        @(negedge clk);
    endtask

    task automatic send_vector(input int len);
        for (int i = 0; i < len; i++)
            send_pair(pick_elem(), pick_elem(), i == len - 1);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input logic [MW-1:0] m);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int target);
        int start;
        start = pairs_sent;
        while (pairs_sent - start < target)
        begin
            write_mode(MW'($urandom_range(3)));
            repeat ($urandom_range(2, 3))
                send_vector(($urandom_range(9) == 0) ? $urandom_range(7, 10)
                                                     : $urandom_range(1, 6));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        elem_a = '0;
        elem_b = '0;
        last_elem = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = vdm_pkg::MODE_RESET;
        out_ready = 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold = 0;
        cycles = 0;
        pairs_sent = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_pair(16'sh7FFF, 16'sh8000, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b0);
        send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
        write_mode(vdm_pkg::MODE_INNER);
        send_pair(16'sd0, 16'sd0, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b1);
        send_pair(16'sh8000, 16'sh7FFF, 1'b0);
        send_pair(16'sh8000, 16'sh7FFF, 1'b1);
        write_mode(vdm_pkg::MODE_COSINE);
        send_pair(16'sd0, 16'sd5, 1'b1);
        send_pair(16'sd7, 16'sd0, 1'b1);
        send_pair(16'sd300, 16'sd300, 1'b1);
        send_pair(16'sh8000, 16'sh7FFF, 1'b1);
        send_pair(16'sd256, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sd256, 1'b1);
        send_pair(16'sh7FFF, 16'sd3, 1'b0);
        send_pair(-16'sd5, 16'sh8000, 1'b1);
        write_mode(2'd3);
        send_pair(16'sh8000, 16'sh7FFF, 1'b0);
        send_pair(16'sd100, -16'sd100, 1'b1);

        tx_idle_pct = 24;
        rx_idle_pct = 85;
        random_phase(16);

        tx_idle_pct = 85;
        rx_idle_pct = 24;
        random_phase(16);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_mode(vdm_pkg::MODE_INNER);
        rx_hold = 400;
        repeat (12) send_vector(1);
        wait_idle();
        write_mode(vdm_pkg::MODE_COSINE);
        send_vector(1025);

        wait_idle();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/vdm_pkg.sv
rtl/core/vdm_front.sv
rtl/core/vdm_queue.sv
rtl/core/vdm_back.sv
rtl/core/vector_distance_metric_top.sv
tb/vdm_checker.sv
tb/tb_top.sv
